// ===== sv/assert_macros.svh =====
// assertion macros for the rtl, included by motion_vector_change_detector.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b on every clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error(msg);

// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error(msg);

`endif

// ===== sv/mvcd_pkg.sv =====
// package for the motion vector change detector: widths, codes, shared types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mvcd_pkg;

    localparam int MaxBlocks = 8192;
    localparam int CountW = 15;
    localparam int RunW = 8;
    localparam int ByteW = 8;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 15;

    localparam int CountCapInt = (2 * MaxBlocks < 32767) ? 2 * MaxBlocks : 32767;
    localparam logic [CountW-1:0] COUNT_CAP = CountW'(CountCapInt);
    localparam logic [ByteW-1:0] NOISE_TOP = 8'd255;
    localparam logic [RunW-1:0] RUN_MAX = 8'd255;

    localparam logic [CfgIdxW-1:0] REG_DETECT_ENABLE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MASK_ENABLE = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_NOISE_LEVEL = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_CHANGE_THRESHOLD = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_START_FRAMES = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_STOP_FRAMES = 3'd5;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_STOP = 2'd2;

    typedef struct packed {
        logic       active;
        logic [1:0] event_code;
    } t_motion_status;

    typedef struct packed {
        logic [CountW-1:0] change_threshold;
        logic [RunW-1:0]   start_frames;
        logic [RunW-1:0]   stop_frames;
    } t_fsm_cfg;

endpackage

`default_nettype wire

// ===== sv/mvcd_motion_fsm.sv =====
// idle/motion state machine with its consecutive-frame run counter
// depends on mvcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mvcd_motion_fsm (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_frame_end,
    input  wire logic [mvcd_pkg::CountW-1:0] i_total,
    input  wire mvcd_pkg::t_fsm_cfg          i_cfg,
    output mvcd_pkg::t_motion_status         o_status
);

    logic                      r_in_motion;
    logic                      n_in_motion;
    logic [mvcd_pkg::RunW-1:0] r_run_frames;
    logic [mvcd_pkg::RunW-1:0] n_run_frames;
    logic [mvcd_pkg::RunW-1:0] run_inc;
    logic [mvcd_pkg::RunW-1:0] target;
    logic                      qualifies;
    logic [1:0]                event_code;

    always_comb begin
        qualifies = r_in_motion ? (i_total < i_cfg.change_threshold)
                                : (i_total >= i_cfg.change_threshold);
        run_inc = (r_run_frames < mvcd_pkg::RUN_MAX) ? r_run_frames + 1'b1 : r_run_frames;
        target = r_in_motion ? i_cfg.stop_frames : i_cfg.start_frames;
        n_in_motion = r_in_motion;
        n_run_frames = r_run_frames;
        event_code = mvcd_pkg::EV_NONE;
        if (i_frame_end) begin
            if (qualifies) begin
                if (run_inc >= target) begin
                    event_code = r_in_motion ? mvcd_pkg::EV_STOP : mvcd_pkg::EV_START;
                    n_run_frames = '0;
                    n_in_motion = ~r_in_motion;
                end else begin
                    n_run_frames = run_inc;
                end
            end else begin
                n_run_frames = '0;
            end
        end
        o_status.active = n_in_motion;
        o_status.event_code = event_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_motion <= 1'b0;
            r_run_frames <= '0;
        end else begin
            r_in_motion <= n_in_motion;
            r_run_frames <= n_run_frames;
        end
    end

endmodule

`default_nettype wire

// ===== sv/motion_vector_change_detector.sv =====
// an accepted item is held in the input register; a frame result then goes to the result register
// throughput: one item per cycle; an item with a result waits only while the result
// register is full and not being taken
// reset: synchronous active low; clears config registers, frame count, run counter, state, valids
// depends on mvcd_pkg, mvcd_motion_fsm and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module motion_vector_change_detector (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [mvcd_pkg::ByteW-1:0]    i_vec_x,
    input  wire logic [mvcd_pkg::ByteW-1:0]    i_vec_y,
    input  wire logic                          i_mask_bit,
    input  wire logic                          i_end_of_frame,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [mvcd_pkg::CountW-1:0]        o_change_count,
    output logic                               o_motion_active,
    output logic [1:0]                         o_motion_event,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mvcd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [mvcd_pkg::CfgDataW-1:0] i_cfg_data
);

    // configuration registers
    logic                        r_detect_enable;
    logic                        r_mask_enable;
    logic [mvcd_pkg::ByteW-1:0]  r_noise_level;
    logic [mvcd_pkg::CountW-1:0] r_change_threshold;
    logic [mvcd_pkg::RunW-1:0]   r_start_frames;
    logic [mvcd_pkg::RunW-1:0]   r_stop_frames;

    // input register
    logic                        r_in_valid;
    logic [mvcd_pkg::ByteW-1:0]  r_vec_x;
    logic [mvcd_pkg::ByteW-1:0]  r_vec_y;
    logic                        r_mask_bit;
    logic                        r_end_of_frame;

    // frame count and result register
    logic [mvcd_pkg::CountW-1:0] r_frame_changes;
    logic [mvcd_pkg::CountW-1:0] n_frame_changes;
    logic                        r_out_valid;
    logic [mvcd_pkg::CountW-1:0] r_change_count;
    logic                        r_motion_active;
    logic [1:0]                  r_motion_event;

    logic [mvcd_pkg::ByteW-1:0]  band_high;
    logic                        x_in_band;
    logic                        y_in_band;
    logic                        block_on;
    logic [mvcd_pkg::CountW:0]   sum;
    logic [mvcd_pkg::CountW-1:0] total;
    logic                        has_result;
    logic                        advance;
    logic                        frame_end;
    mvcd_pkg::t_fsm_cfg          fsm_cfg;
    mvcd_pkg::t_motion_status    status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_enable <= 1'b0;
            r_mask_enable <= 1'b0;
            r_noise_level <= '0;
            r_change_threshold <= '0;
            r_start_frames <= '0;
            r_stop_frames <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mvcd_pkg::REG_DETECT_ENABLE:    r_detect_enable <= i_cfg_data[0];
                mvcd_pkg::REG_MASK_ENABLE:      r_mask_enable <= i_cfg_data[0];
                mvcd_pkg::REG_NOISE_LEVEL:      r_noise_level <= i_cfg_data[7:0];
                mvcd_pkg::REG_CHANGE_THRESHOLD: r_change_threshold <= i_cfg_data;
                mvcd_pkg::REG_START_FRAMES:     r_start_frames <= i_cfg_data[7:0];
                mvcd_pkg::REG_STOP_FRAMES:      r_stop_frames <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // band test and running count
    always_comb begin
        band_high = mvcd_pkg::NOISE_TOP - r_noise_level;
        x_in_band = (r_vec_x > r_noise_level) && (r_vec_x < band_high);
        y_in_band = (r_vec_y > r_noise_level) && (r_vec_y < band_high);
        block_on = !r_mask_enable || r_mask_bit;
        sum = {1'b0, r_frame_changes};
        if (block_on) begin
            sum = sum + (mvcd_pkg::CountW + 1)'(x_in_band) + (mvcd_pkg::CountW + 1)'(y_in_band);
        end
        total = (sum > {1'b0, mvcd_pkg::COUNT_CAP}) ? mvcd_pkg::COUNT_CAP
                                                    : sum[mvcd_pkg::CountW-1:0];
        has_result = r_detect_enable && r_end_of_frame;
        advance = r_in_valid && (!has_result || !r_out_valid || i_out_ready);
        frame_end = advance && has_result;
        n_frame_changes = r_frame_changes;
        if (advance) begin
            if (!r_detect_enable || r_end_of_frame) begin
                n_frame_changes = '0;
            end else begin
                n_frame_changes = total;
            end
        end
    end

    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        fsm_cfg.change_threshold = r_change_threshold;
        fsm_cfg.start_frames = r_start_frames;
        fsm_cfg.stop_frames = r_stop_frames;
    end

    mvcd_motion_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame_end (frame_end),
        .i_total     (total),
        .i_cfg       (fsm_cfg),
        .o_status    (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_frame_changes <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (frame_end) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_frame_changes <= n_frame_changes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_vec_x <= i_vec_x;
            r_vec_y <= i_vec_y;
            r_mask_bit <= i_mask_bit;
            r_end_of_frame <= i_end_of_frame;
        end
        if (frame_end) begin
            r_change_count <= total;
            r_motion_active <= status.active;
            r_motion_event <= status.event_code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_change_count = r_change_count;
    assign o_motion_active = r_motion_active;
    assign o_motion_event = r_motion_event;

    `ASSERT_IMPLIES(a_start_sets_active, i_clk, i_rst_n,
        o_out_valid && (o_motion_event == mvcd_pkg::EV_START), o_motion_active,
        "start event without motion state")
    `ASSERT_IMPLIES(a_stop_clears_active, i_clk, i_rst_n,
        o_out_valid && (o_motion_event == mvcd_pkg::EV_STOP), !o_motion_active,
        "stop event while still in motion")
    `ASSERT_IMPLIES(a_count_capped, i_clk, i_rst_n,
        r_in_valid, r_frame_changes <= mvcd_pkg::COUNT_CAP,
        "frame count above cap")
    `ASSERT_NEXT(a_disabled_clears_count, i_clk, i_rst_n,
        advance && !r_detect_enable, r_frame_changes == '0,
        "frame count kept while detection disabled")

endmodule

`default_nettype wire

// ===== bench/mvcd_frame_checker.sv =====
// frame report checker for the motion vector change detector: watches the item, result
// and register channels, predicts each frame report and compares it field by field
// depends on mvcd_pkg
`timescale 1ns / 1ps

module mvcd_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [mvcd_pkg::ByteW-1:0]    i_vec_x,
    input  logic [mvcd_pkg::ByteW-1:0]    i_vec_y,
    input  logic                          i_mask_bit,
    input  logic                          i_end_of_frame,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [mvcd_pkg::CountW-1:0]   i_change_count,
    input  logic                          i_motion_active,
    input  logic [1:0]                    i_motion_event,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [mvcd_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [mvcd_pkg::CfgDataW-1:0] i_cfg_data,
    output int                            o_mismatches,
    output int                            o_pending
);
    import mvcd_pkg::*;

    typedef struct packed {
        logic [CountW-1:0] count;
        t_motion_status    status;
    } t_frame_report;

    t_frame_report frame_reports_due[$];
    int mismatch_total = 0;

    // register copies
    logic              detect_en;
    logic              mask_en;
    logic [ByteW-1:0]  noise;
    logic [CountW-1:0] thresh;
    logic [RunW-1:0]   start_need;
    logic [RunW-1:0]   stop_need;

    // detector state
    logic [CountW-1:0] frame_acc;
    logic [RunW-1:0]   run_len;
    logic              moving;

    initial begin
        o_mismatches = 0;
        o_pending = 0;
    end

    function automatic int in_band(input logic [ByteW-1:0] c);
        logic [ByteW-1:0] hi;
        hi = NOISE_TOP - noise;
        return (c > noise && c < hi) ? 1 : 0;
    endfunction

    task automatic predict_block(input logic [ByteW-1:0] vx, input logic [ByteW-1:0] vy,
                                 input logic mbit, input logic eof);
        int total;
        logic qual;
        logic [RunW-1:0] need;
        t_frame_report rep;
        if (!detect_en) begin
            frame_acc = '0;
            return;
        end
        total = int'(frame_acc);
        if (!mask_en || mbit) begin
            total += in_band(vx) + in_band(vy);
        end
        if (total > int'(COUNT_CAP)) begin
            total = int'(COUNT_CAP);
        end
        if (!eof) begin
            frame_acc = CountW'(total);
            return;
        end
        frame_acc = '0;
        qual = moving ? (total < int'(thresh)) : (total >= int'(thresh));
        rep.status.event_code = EV_NONE;
        if (qual) begin
            if (run_len < RUN_MAX) begin
                run_len = run_len + 1'b1;
            end
            need = moving ? stop_need : start_need;
            if (run_len >= need) begin
                rep.status.event_code = moving ? EV_STOP : EV_START;
                run_len = '0;
                moving = !moving;
            end
        end else begin
            run_len = '0;
        end
        rep.count = CountW'(total);
        rep.status.active = moving;
        frame_reports_due.push_back(rep);
    endtask

    always @(posedge i_clk) begin
        t_frame_report got;
        t_frame_report want;
        if (!i_rst_n) begin
            detect_en = 1'b0;
            mask_en = 1'b0;
            noise = '0;
            thresh = '0;
            start_need = '0;
            stop_need = '0;
            frame_acc = '0;
            run_len = '0;
            moving = 1'b0;
            frame_reports_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.count = i_change_count;
                got.status.active = i_motion_active;
                got.status.event_code = i_motion_event;
                if (frame_reports_due.size() == 0) begin
                    $display("%0t unexpected report count %0d active %0d event %0d",
                             $time, got.count, got.status.active, got.status.event_code);
                    mismatch_total++;
                end else begin
                    want = frame_reports_due.pop_front();
                    if (got.count !== want.count) begin
                        $display("%0t change_count expected %0d actual %0d",
                                 $time, want.count, got.count);
                        mismatch_total++;
                    end
                    if (got.status.active !== want.status.active) begin
                        $display("%0t motion_active expected %0d actual %0d",
                                 $time, want.status.active, got.status.active);
                        mismatch_total++;
                    end
                    if (got.status.event_code !== want.status.event_code) begin
                        $display("%0t motion_event expected %0d actual %0d",
                                 $time, want.status.event_code, got.status.event_code);
                        mismatch_total++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DETECT_ENABLE: detect_en = i_cfg_data[0];
                    REG_MASK_ENABLE: mask_en = i_cfg_data[0];
                    REG_NOISE_LEVEL: noise = i_cfg_data[ByteW-1:0];
                    REG_CHANGE_THRESHOLD: thresh = i_cfg_data[CountW-1:0];
                    REG_START_FRAMES: start_need = i_cfg_data[RunW-1:0];
                    REG_STOP_FRAMES: stop_need = i_cfg_data[RunW-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_block(i_vec_x, i_vec_y, i_mask_bit, i_end_of_frame);
            end
        end
        o_pending <= frame_reports_due.size();
        o_mismatches <= mismatch_total;
    end

endmodule

// ===== bench/tb_motion_vector_change_detector.sv =====
// testbench top for the motion vector change detector: clock, reset, directed and random
// block items, register writes, result stalls and the final verdict
// depends on mvcd_pkg, motion_vector_change_detector and mvcd_frame_checker
`timescale 1ns / 1ps

module tb_motion_vector_change_detector;
    import mvcd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic [ByteW-1:0]    i_vec_x = '0;
    logic [ByteW-1:0]    i_vec_y = '0;
    logic                i_mask_bit = 1'b0;
    logic                i_end_of_frame = 1'b0;
    logic                i_out_ready = 1'b1;
    logic                i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic [CountW-1:0]   o_change_count;
    logic                o_motion_active;
    logic [1:0]          o_motion_event;
    logic                o_cfg_ready;

    int   mismatches;
    int   reports_pending;
    int   cycle_count = 0;
    int   stall_left = 0;
    logic steady = 1'b0;

    motion_vector_change_detector u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_vec_x        (i_vec_x),
        .i_vec_y        (i_vec_y),
        .i_mask_bit     (i_mask_bit),
        .i_end_of_frame (i_end_of_frame),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_change_count (o_change_count),
        .o_motion_active(o_motion_active),
        .o_motion_event (o_motion_event),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    mvcd_frame_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_vec_x        (i_vec_x),
        .i_vec_y        (i_vec_y),
        .i_mask_bit     (i_mask_bit),
        .i_end_of_frame (i_end_of_frame),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_change_count (o_change_count),
        .i_motion_active(o_motion_active),
        .i_motion_event (o_motion_event),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (reports_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side stalls
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < 20) begin
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50)
                                                        : $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ByteW-1:0] pick_component(input logic [ByteW-1:0] nl);
        case ($urandom_range(0, 7))
            0: return nl;
            1: return nl + 8'd1;
            2: return NOISE_TOP - nl;
            3: return NOISE_TOP - nl - 8'd1;
            default: return ByteW'($urandom);
        endcase
    endfunction

    task automatic send_block(input logic [ByteW-1:0] x, input logic [ByteW-1:0] y,
                              input logic m, input logic e);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_vec_x <= x;
        i_vec_y <= y;
        i_mask_bit <= m;
        i_end_of_frame <= e;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_frame(input int len, input logic [ByteW-1:0] nl);
        for (int i = 0; i < len; i++) begin
            send_block(pick_component(nl), pick_component(nl), $urandom_range(0, 3) != 0,
                       i == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (reports_pending != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic de, input logic me, input logic [ByteW-1:0] nl,
                             input logic [CountW-1:0] th, input logic [RunW-1:0] sf,
                             input logic [RunW-1:0] pf);
        settle();
        write_reg(REG_DETECT_ENABLE, CfgDataW'(de));
        write_reg(REG_MASK_ENABLE, CfgDataW'(me));
        write_reg(REG_NOISE_LEVEL, CfgDataW'(nl));
        write_reg(REG_CHANGE_THRESHOLD, CfgDataW'(th));
        write_reg(REG_START_FRAMES, CfgDataW'(sf));
        write_reg(REG_STOP_FRAMES, CfgDataW'(pf));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int sent;
        int len;
        logic me;
        logic [ByteW-1:0] nl;
        logic [CountW-1:0] th;
        logic [RunW-1:0] sf;
        logic [RunW-1:0] pf;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // detection off after reset
        send_block(8'd100, 8'd100, 1'b0, 1'b1);

        // full band, zero run targets, spare indexes ignored
        configure(1'b1, 1'b0, 8'd0, 15'd1, 8'd0, 8'd0);
        write_reg(REG_SPARE_LO, 15'h7fff);
        write_reg(REG_SPARE_HI, 15'h7fff);
        i_cfg_valid <= 1'b0;
        send_block(8'd0, 8'd255, 1'b0, 1'b1);
        send_block(8'd1, 8'd254, 1'b0, 1'b1);
        send_block(8'd255, 8'd0, 1'b1, 1'b1);
        send_block(8'haa, 8'h55, 1'b0, 1'b0);
        send_block(8'h55, 8'haa, 1'b1, 1'b1);

        // narrow band with mask honored
        configure(1'b1, 1'b1, 8'd126, 15'd2, 8'd1, 8'd2);
        send_block(8'd127, 8'd128, 1'b1, 1'b0);
        send_block(8'd127, 8'd128, 1'b0, 1'b0);
        send_block(8'd126, 8'd129, 1'b1, 1'b1);
        send_block(8'd128, 8'd127, 1'b1, 1'b1);
        send_block(8'd0, 8'd0, 1'b1, 1'b1);
        send_block(8'd255, 8'd255, 1'b1, 1'b1);

        // empty bands
        configure(1'b1, 1'b0, 8'd255, 15'd0, 8'd0, 8'd0);
        send_block(8'd127, 8'd128, 1'b1, 1'b1);
        send_block(8'd200, 8'd50, 1'b0, 1'b1);
        configure(1'b1, 1'b0, 8'd127, 15'h7fff, 8'd3, 8'd0);
        send_block(8'd127, 8'd128, 1'b1, 1'b1);

        // detection dropped mid frame clears the partial count
        configure(1'b1, 1'b0, 8'd10, 15'd1, 8'd0, 8'd0);
        send_block(8'd50, 8'd60, 1'b1, 1'b0);
        send_block(8'd50, 8'd60, 1'b1, 1'b0);
        settle();
        write_reg(REG_DETECT_ENABLE, 15'd0);
        i_cfg_valid <= 1'b0;
        send_block(8'd50, 8'd60, 1'b1, 1'b1);
        settle();
        write_reg(REG_DETECT_ENABLE, 15'd1);
        i_cfg_valid <= 1'b0;
        send_block(8'd50, 8'd9, 1'b1, 1'b1);
        send_block(8'd11, 8'd245, 1'b0, 1'b1);
        send_block(8'd10, 8'd244, 1'b0, 1'b1);

        // random phases
        for (int p = 0; p < 4; p++) begin
            me = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: nl = 8'd0;
                1: nl = 8'd255;
                2: nl = ByteW'($urandom_range(100, 127));
                default: nl = ByteW'($urandom_range(0, 80));
            endcase
            case ($urandom_range(0, 9))
                0: th = 15'd0;
                1: th = COUNT_CAP;
                2: th = 15'h7fff;
                default: th = CountW'($urandom_range(1, 12));
            endcase
            sf = ($urandom_range(0, 9) == 0) ? RUN_MAX : RunW'($urandom_range(0, 4));
            pf = ($urandom_range(0, 9) == 0) ? RUN_MAX : RunW'($urandom_range(0, 4));
            configure(1'b1, me, nl, th, sf, pf);
            steady <= ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < 130) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 6);
                send_frame(len, nl);
                sent += len;
                if ($urandom_range(0, 29) == 0) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                end
            end
        end

        // run counter up to its top value in both directions
        configure(1'b1, 1'b1, 8'd0, 15'd0, RUN_MAX, RUN_MAX);
        steady <= 1'b0;
        for (int f = 0; f < 258; f++) begin
            send_frame(1, 8'd0);
        end
        settle();
        write_reg(REG_CHANGE_THRESHOLD, 15'h7fff);
        i_cfg_valid <= 1'b0;
        for (int f = 0; f < 256; f++) begin
            send_frame(1, 8'd0);
        end

        // back to back items with no stalls, then a short stalled frame
        configure(1'b1, 1'b0, 8'd0, 15'd4, 8'd0, 8'd1);
        steady <= 1'b1;
        send_frame(24, 8'd0);
        steady <= 1'b0;
        send_frame(10, 8'd0);

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && reports_pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
